FILE: hdl/mrks_pkg.sv
// Shared types, keyword tables and codes for the modem response keyword scanner.
// Used by mrks_match, mrks_ctrl and modem_response_keyword_scanner.
`default_nettype none
package mrks_pkg;

  localparam int WINDOW_BYTES      = 10;
  localparam int LONG_REPLY_LIMIT  = 2048;
  localparam int SHORT_REPLY_LIMIT = 200;

  localparam int KW_COUNT   = 6;
  localparam int KW_MAX_LEN = 8;

  localparam int KW_OK      = 0;
  localparam int KW_ERROR   = 1;
  localparam int KW_HTTP    = 2;
  localparam int KW_200     = 3;
  localparam int KW_CLOSED  = 4;
  localparam int KW_ALREADY = 5;

  typedef logic [7:0]          byte_t;
  typedef logic [KW_COUNT-1:0] kw_mask_t;
  typedef logic [3:0]          kw_len_t;
  typedef logic [2:0]          kw_sel_t;
  typedef logic [15:0]         count_t;
  typedef logic [31:0]         ticks_t;

  // Keyword text stored last character first: entry j is j bytes back from the newest byte.
  localparam byte_t KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{8'h4B, 8'h4F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h52, 8'h4F, 8'h52, 8'h52, 8'h45, 8'h00, 8'h00, 8'h00},
    '{8'h31, 8'h2E, 8'h31, 8'h2F, 8'h50, 8'h54, 8'h54, 8'h48},
    '{8'h4B, 8'h4F, 8'h20, 8'h30, 8'h30, 8'h32, 8'h00, 8'h00},
    '{8'h44, 8'h45, 8'h53, 8'h4F, 8'h4C, 8'h43, 8'h00, 8'h00},
    '{8'h59, 8'h44, 8'h41, 8'h45, 8'h52, 8'h4C, 8'h41, 8'h00}
  };
  localparam kw_len_t KW_LEN [KW_COUNT] = '{4'd2, 4'd5, 4'd8, 4'd6, 4'd6, 4'd7};

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TIMEOUT  = 3'd1,
    ERR_ALREADY  = 3'd2,
    ERR_HTTP     = 3'd3,
    ERR_OVERFLOW = 3'd4,
    ERR_OTHER    = 3'd5
  } err_t;

  typedef enum logic [0:0] {
    CFG_EXPECTED = 1'b0,
    CFG_TIMEOUT  = 1'b1
  } cfg_idx_t;

  localparam ticks_t TIMEOUT_RESET = 32'd5000;

  typedef struct packed {
    logic clear;
    logic shift;
  } win_ctl_t;

  typedef struct packed {
    logic     done_res;
    logic     success;
    err_t     error_code;
    count_t   reply_length;
    logic     overflowed;
    kw_mask_t seen_mask;
    count_t   http_fail_total;
    count_t   timeout_total;
    count_t   overflow_total;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/mrks_match.sv
// Sliding byte window and the six parallel keyword comparators.
// Depends on mrks_pkg.
`default_nettype none
module mrks_match (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mrks_pkg::win_ctl_t win_ctl,
  input  wire mrks_pkg::byte_t   rx_byte,
  output mrks_pkg::kw_mask_t     match
);
  import mrks_pkg::*;

  byte_t window [WINDOW_BYTES];
  byte_t shifted [WINDOW_BYTES];

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      shifted[i] = window[i+1];
    end
    shifted[WINDOW_BYTES-1] = rx_byte;
  end

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      match[k] = 1'b1;
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if (kw_len_t'(j) < KW_LEN[k] && shifted[WINDOW_BYTES-1-j] != KW_TEXT[k][j]) begin
          match[k] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || win_ctl.clear) begin
      for (int i = 0; i < WINDOW_BYTES; i++) begin
        window[i] <= '0;
      end
    end else if (win_ctl.shift) begin
      window <= shifted;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mrks_ctrl.sv
// Command status, fail counters and finish classification for the scanner.
// Depends on mrks_pkg; takes keyword hits from mrks_match.
`default_nettype none
module mrks_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic [1:0]         op,
  input  wire mrks_pkg::byte_t    rx_byte,
  input  wire mrks_pkg::kw_sel_t  expected_keyword,
  input  wire mrks_pkg::ticks_t   timeout_ticks,
  input  wire mrks_pkg::kw_mask_t match,
  output mrks_pkg::win_ctl_t      win_ctl,
  output mrks_pkg::result_t       result
);
  import mrks_pkg::*;

  kw_mask_t seen_flags, seen_flags_next;
  logic     matched_done, matched_done_next;
  logic     timed_out, timed_out_next;
  logic     overflow_flag, overflow_flag_next;
  count_t   byte_count, byte_count_next;
  ticks_t   elapsed_ticks, elapsed_ticks_next;
  count_t   http_fail_count, http_fail_count_next;
  count_t   timeout_count, timeout_count_next;
  count_t   overflow_count, overflow_count_next;

  logic     done, finish, do_shift, do_clear, http_now, hit, no_200;
  kw_mask_t gated;
  count_t   limit;
  err_t     code;

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + 16'd1;
  endfunction

  assign done  = matched_done | timed_out;
  assign limit = (expected_keyword == kw_sel_t'(KW_CLOSED)) ? count_t'(LONG_REPLY_LIMIT)
                                                            : count_t'(SHORT_REPLY_LIMIT);
  assign http_now = seen_flags[KW_HTTP] | match[KW_HTTP];

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      gated[k] = match[k] & ((k != KW_200 && k != KW_CLOSED) | http_now);
      if (gated[k] && (expected_keyword == kw_sel_t'(k) || k == KW_ERROR)) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    seen_flags_next    = seen_flags;
    matched_done_next  = matched_done;
    timed_out_next     = timed_out;
    overflow_flag_next = overflow_flag;
    byte_count_next    = byte_count;
    elapsed_ticks_next = elapsed_ticks;
    finish             = 1'b0;
    do_shift           = 1'b0;
    do_clear           = 1'b0;
    unique case (op)
      OP_START: begin
        do_clear           = 1'b1;
        seen_flags_next    = '0;
        matched_done_next  = 1'b0;
        timed_out_next     = 1'b0;
        overflow_flag_next = 1'b0;
        byte_count_next    = '0;
        elapsed_ticks_next = '0;
      end
      OP_BYTE: begin
        if (!done && rx_byte != 8'd0) begin
          byte_count_next = sat_inc(byte_count);
          if (byte_count_next >= limit) begin
            overflow_flag_next = 1'b1;
          end else if (!seen_flags[KW_ERROR] && !seen_flags[KW_CLOSED]) begin
            do_shift        = 1'b1;
            seen_flags_next = seen_flags | gated;
            if (hit) begin
              matched_done_next = 1'b1;
              finish            = 1'b1;
            end
          end
        end
      end
      OP_TICK: begin
        if (!done) begin
          elapsed_ticks_next = (elapsed_ticks == '1) ? elapsed_ticks : elapsed_ticks + 32'd1;
          if (elapsed_ticks_next > timeout_ticks) begin
            timed_out_next = 1'b1;
            finish         = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign no_200 = seen_flags_next[KW_HTTP] & ~seen_flags_next[KW_200];

  always_comb begin
    overflow_count_next  = overflow_count;
    timeout_count_next   = timeout_count;
    http_fail_count_next = http_fail_count;
    if (finish) begin
      if (overflow_flag_next) begin
        overflow_count_next = sat_inc(overflow_count);
      end
      if (timed_out_next) begin
        timeout_count_next = sat_inc(timeout_count);
      end else if (!seen_flags_next[KW_ALREADY] && no_200) begin
        http_fail_count_next = sat_inc(http_fail_count);
      end
    end
  end

  always_comb begin
    priority if (!(matched_done_next || timed_out_next)) begin
      code = ERR_NONE;
    end else if (timed_out_next) begin
      code = ERR_TIMEOUT;
    end else if (seen_flags_next[KW_ALREADY]) begin
      code = ERR_ALREADY;
    end else if (no_200) begin
      code = ERR_HTTP;
    end else if (overflow_flag_next) begin
      code = ERR_OVERFLOW;
    end else if (seen_flags_next[KW_ERROR]) begin
      code = ERR_OTHER;
    end else begin
      code = ERR_NONE;
    end
  end

  always_comb begin
    result.done_res        = matched_done_next | timed_out_next;
    result.success         = (matched_done_next | timed_out_next) && code == ERR_NONE;
    result.error_code      = code;
    result.reply_length    = byte_count_next;
    result.overflowed      = overflow_flag_next;
    result.seen_mask       = seen_flags_next;
    result.http_fail_total = http_fail_count_next;
    result.timeout_total   = timeout_count_next;
    result.overflow_total  = overflow_count_next;
  end

  assign win_ctl.clear = adv & do_clear;
  assign win_ctl.shift = adv & do_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_flags      <= '0;
      matched_done    <= 1'b0;
      timed_out       <= 1'b0;
      overflow_flag   <= 1'b0;
      byte_count      <= '0;
      elapsed_ticks   <= '0;
      http_fail_count <= '0;
      timeout_count   <= '0;
      overflow_count  <= '0;
    end else if (adv) begin
      seen_flags      <= seen_flags_next;
      matched_done    <= matched_done_next;
      timed_out       <= timed_out_next;
      overflow_flag   <= overflow_flag_next;
      byte_count      <= byte_count_next;
      elapsed_ticks   <= elapsed_ticks_next;
      http_fail_count <= http_fail_count_next;
      timeout_count   <= timeout_count_next;
      overflow_count  <= overflow_count_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/modem_response_keyword_scanner.sv
// Top level of the modem response keyword scanner: input register, result register, config.
// Depends on mrks_pkg, mrks_match and mrks_ctrl.
//
// Every accepted word (command start, reply byte or timer tick) gives exactly one result
// word. A new word is taken every cycle unless in_stall is high; a word is held in the input
// register and then loaded into the result register when it advances. The cycle is set
// by the ten-byte window feeding six keyword comparators in parallel, followed by the status
// and counter update. While a result waits on out_stall, one further word is held in the
// input register before in_stall rises. Write configuration only while no word is in flight.
`default_nettype none
module modem_response_keyword_scanner (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             done_res,
  output logic             success,
  output logic [2:0]       error_code,
  output logic [15:0]      reply_length,
  output logic             overflowed,
  output logic [5:0]       seen_mask,
  output logic [15:0]      http_fail_total,
  output logic [15:0]      timeout_total,
  output logic [15:0]      overflow_total
);
  import mrks_pkg::*;

  kw_sel_t    expected_keyword;
  ticks_t     timeout_ticks;
  logic       s_valid;
  logic [1:0] s_op;
  byte_t      s_byte;
  logic       adv;
  win_ctl_t   win_ctl;
  kw_mask_t   match;
  result_t    result;
  result_t    out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_keyword <= kw_sel_t'(KW_OK);
      timeout_ticks    <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_EXPECTED: expected_keyword <= cfg_data[2:0];
        CFG_TIMEOUT:  timeout_ticks    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign adv      = s_valid & (~out_valid | ~out_stall);
  assign in_stall = s_valid & ~adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s_op   <= op;
      s_byte <= rx_byte;
    end
  end

  mrks_match u_match (
    .clk     (clk),
    .rst     (rst),
    .win_ctl (win_ctl),
    .rx_byte (s_byte),
    .match   (match)
  );

  mrks_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .adv              (adv),
    .op               (s_op),
    .rx_byte          (s_byte),
    .expected_keyword (expected_keyword),
    .timeout_ticks    (timeout_ticks),
    .match            (match),
    .win_ctl          (win_ctl),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_reg <= result;
    end
  end

  assign done_res        = out_reg.done_res;
  assign success         = out_reg.success;
  assign error_code      = out_reg.error_code;
  assign reply_length    = out_reg.reply_length;
  assign overflowed      = out_reg.overflowed;
  assign seen_mask       = out_reg.seen_mask;
  assign http_fail_total = out_reg.http_fail_total;
  assign timeout_total   = out_reg.timeout_total;
  assign overflow_total  = out_reg.overflow_total;

  a_success_finished: assert property (@(posedge clk) disable iff (rst)
    out_valid && success |-> done_res && error_code == ERR_NONE)
    else $error("success reported without a clean finish");

  a_open_no_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> error_code == ERR_NONE && !success)
    else $error("error code reported for an open command");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s_valid && out_valid && out_stall)
    else $error("input stalled while the pipeline has room");

  a_adv_loads_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("advanced word did not reach the result register");

endmodule
`default_nettype wire

FILE: tb/tb_modem_response_keyword_scanner.sv
// Self-checking bench for modem_response_keyword_scanner: starts, reply bytes and ticks in,
// one status word out per word in, checked against an in-bench scanner model.
// Depends on mrks_pkg and the scanner RTL only.
`default_nettype none
module tb_modem_response_keyword_scanner;
  import mrks_pkg::*;

  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [1:0] op;
    byte_t      data;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_EXPECTED;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = OP_START;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        done_res;
  logic        success;
  logic [2:0]  error_code;
  logic [15:0] reply_length;
  logic        overflowed;
  logic [5:0]  seen_mask;
  logic [15:0] http_fail_total;
  logic [15:0] timeout_total;
  logic [15:0] overflow_total;

  modem_response_keyword_scanner dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .done_res(done_res), .success(success), .error_code(error_code),
    .reply_length(reply_length), .overflowed(overflowed), .seen_mask(seen_mask),
    .http_fail_total(http_fail_total), .timeout_total(timeout_total),
    .overflow_total(overflow_total)
  );

  always #2 clk = ~clk;

  // Scanner model state and its copy of the registers
  string    keyword_text [KW_COUNT] = '{"OK", "ERROR", "HTTP/1.1", "200 OK", "CLOSED",
                                        "ALREADY"};
  string    reply_parts [10] = '{"OK", "ERROR", "HTTP/1.1", "200 OK", "CLOSED", "ALREADY",
                                 "HTTP/1.1 200 OK", "HTTP/1.1 404 Not Found",
                                 "ALREADY CONNECTED", "\r\n"};
  byte_t    win [WINDOW_BYTES];
  kw_mask_t kw_seen = '0;
  logic     kw_matched = 1'b0;
  logic     cmd_timed_out = 1'b0;
  logic     long_reply = 1'b0;
  count_t   reply_cnt = '0;
  ticks_t   tick_cnt = '0;
  count_t   http_fails = '0;
  count_t   timeouts = '0;
  count_t   overflows = '0;
  kw_sel_t  want_kw = kw_sel_t'(KW_OK);
  ticks_t   tmo_ticks = TIMEOUT_RESET;

  word_t    tx_words [$];
  result_t  status_due [$];
  int       words_sent = 0;
  int       words_taken = 0;
  int       bad_count = 0;
  int       cycle_count = 0;
  int       hold_off = 0;
  int       stall_left = 0;
  logic     quiet = 1'b0;

  initial begin
    foreach (win[i]) win[i] = 8'h00;
  end

  function automatic void close_command();
    if (long_reply && overflows != 16'hFFFF) overflows++;
    if (cmd_timed_out) begin
      if (timeouts != 16'hFFFF) timeouts++;
    end else if (!kw_seen[KW_ALREADY] && kw_seen[KW_HTTP] && !kw_seen[KW_200]) begin
      if (http_fails != 16'hFFFF) http_fails++;
    end
  endfunction

  function automatic result_t scanner_status(logic [1:0] o, byte_t b);
    result_t r;
    int      lim;
    int      n;
    logic    hit;
    logic    same;
    logic    fin;
    err_t    code;
    hit = 1'b0;
    if (o == OP_START) begin
      foreach (win[i]) win[i] = 8'h00;
      kw_seen = '0;
      kw_matched = 1'b0;
      cmd_timed_out = 1'b0;
      long_reply = 1'b0;
      reply_cnt = '0;
      tick_cnt = '0;
    end else if (!(kw_matched || cmd_timed_out)) begin
      if (o == OP_BYTE && b != 8'h00) begin
        lim = (want_kw == KW_CLOSED) ? LONG_REPLY_LIMIT : SHORT_REPLY_LIMIT;
        if (reply_cnt != 16'hFFFF) reply_cnt++;
        if (int'(reply_cnt) >= lim) begin
          long_reply = 1'b1;
        end else if (!kw_seen[KW_ERROR] && !kw_seen[KW_CLOSED]) begin
          for (int i = 0; i < WINDOW_BYTES - 1; i++) win[i] = win[i + 1];
          win[WINDOW_BYTES - 1] = b;
          for (int k = 0; k < KW_COUNT; k++) begin
            if ((k == KW_200 || k == KW_CLOSED) && !kw_seen[KW_HTTP]) continue;
            n = keyword_text[k].len();
            same = 1'b1;
            for (int j = 0; j < n; j++)
              if (win[WINDOW_BYTES - n + j] != byte_t'(keyword_text[k][j])) same = 1'b0;
            if (same) begin
              kw_seen[k] = 1'b1;
              if (k == int'(want_kw) || k == KW_ERROR) hit = 1'b1;
            end
          end
          if (hit) begin
            kw_matched = 1'b1;
            close_command();
          end
        end
      end else if (o == OP_TICK) begin
        if (tick_cnt != 32'hFFFF_FFFF) tick_cnt++;
        if (tick_cnt > tmo_ticks) begin
          cmd_timed_out = 1'b1;
          close_command();
        end
      end
    end
    fin = kw_matched || cmd_timed_out;
    if (!fin) code = ERR_NONE;
    else if (cmd_timed_out) code = ERR_TIMEOUT;
    else if (kw_seen[KW_ALREADY]) code = ERR_ALREADY;
    else if (kw_seen[KW_HTTP] && !kw_seen[KW_200]) code = ERR_HTTP;
    else if (long_reply) code = ERR_OVERFLOW;
    else if (kw_seen[KW_ERROR]) code = ERR_OTHER;
    else code = ERR_NONE;
    r.done_res = fin;
    r.success = fin && code == ERR_NONE;
    r.error_code = code;
    r.reply_length = reply_cnt;
    r.overflowed = long_reply;
    r.seen_mask = kw_seen;
    r.http_fail_total = http_fails;
    r.timeout_total = timeouts;
    r.overflow_total = overflows;
    return r;
  endfunction

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  always @(posedge clk) begin : word_driver
    word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      hold_off = 0;
    end else if (!(in_valid && in_stall)) begin
      if (tx_words.size() != 0 && hold_off == 0) begin
        w = tx_words.pop_front();
        in_valid <= 1'b1;
        op <= w.op;
        rx_byte <= w.data;
        hold_off = draw_wait();
      end else begin
        in_valid <= 1'b0;
        if (hold_off != 0) hold_off--;
      end
    end
  end

  always @(posedge clk) begin : status_sink
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      stall_left = draw_wait();
      out_stall <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  task automatic flag_status(string why, result_t want, result_t got);
    bad_count++;
    if (bad_count <= 10) $display("%s: expected %p, got %p", why, want, got);
  endtask

  always @(posedge clk) begin : status_check
    result_t want;
    result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        status_due.push_back(scanner_status(op, rx_byte));
        words_taken++;
      end
      if (out_valid && !out_stall) begin
        got = '{done_res, success, err_t'(error_code), reply_length, overflowed, seen_mask,
                http_fail_total, timeout_total, overflow_total};
        if (status_due.size() == 0) begin
          flag_status("status word with none due", '0, got);
        end else begin
          want = status_due.pop_front();
          if (got !== want) flag_status("status mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] o, byte_t b);
    tx_words.push_back('{o, b});
    words_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(OP_BYTE, byte_t'(s[i]));
  endtask

  // Wait for every word to pass, then let the pipeline drain
  task automatic settle();
    do @(posedge clk); while (words_taken != words_sent || status_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    if (idx == CFG_EXPECTED) want_kw = kw_sel_t'(v[2:0]);
    else tmo_ticks = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_command();
    string s;
    string letters;
    letters = "OKERHTP/1.20 CLSADY";
    if ($urandom_range(0, 9) != 0) send_word(OP_START, byte_t'($urandom_range(0, 255)));
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4, 5, 6: send_text(reply_parts[$urandom_range(0, 9)]);
        7, 8: begin
          s = keyword_text[$urandom_range(0, KW_COUNT - 1)];
          send_text(s.substr(0, $urandom_range(0, s.len() - 2)));
        end
        9: repeat ($urandom_range(1, 4)) send_word(OP_BYTE, byte_t'($urandom_range(0, 255)));
        10, 11: repeat ($urandom_range(1, 3))
          send_word(OP_BYTE, byte_t'(letters[$urandom_range(0, letters.len() - 1)]));
        12, 13: repeat ($urandom_range(1, 3))
          send_word(OP_TICK, byte_t'($urandom_range(0, 255)));
        14: send_word(OP_BYTE, 8'h00);
        default: send_word(OP_SPARE, byte_t'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Out of reset the scanner behaves as if a command had just started
  task automatic test_reset_state();
    send_word(OP_BYTE, "O");
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, "K");
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_TICK, 8'hFF);
    send_word(OP_SPARE, 8'h00);
  endtask

  task automatic test_timeout_bounds();
    settle();
    write_reg(CFG_TIMEOUT, 32'h0000_0000);
    send_word(OP_START, 8'h00);
    send_word(OP_TICK, 8'h00);
    settle();
    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    send_word(OP_START, 8'hFF);
    send_word(OP_TICK, 8'h00);
    send_word(OP_TICK, 8'h00);
    send_text("OK");
  endtask

  task automatic test_unused_keyword();
    settle();
    write_reg(CFG_EXPECTED, 32'h0000_0007);
    send_word(OP_START, 8'h00);
    send_text("OK");
    send_text("ERROR");
  endtask

  task automatic test_reply_overflow();
    settle();
    write_reg(CFG_EXPECTED, {29'($urandom()), 3'(KW_ERROR)});
    write_reg(CFG_TIMEOUT, 32'd2);
    send_word(OP_START, 8'h00);
    repeat (205) send_word(OP_BYTE, byte_t'($urandom_range(8'h61, 8'h7A)));
    send_text("ERROR");
    repeat (3) send_word(OP_TICK, 8'h00);
  endtask

  task automatic test_random_traffic();
    int      kw_list [8] = '{KW_200, KW_OK, KW_CLOSED, KW_ALREADY, KW_HTTP, 7, 0, KW_ERROR};
    ticks_t  tmo_list [8] = '{5000, 0, 12, 32'hFFFF_FFFF, 3, 0, 0, 6};
    int      target;
    kw_list[6] = $urandom_range(0, 7);
    tmo_list[5] = $urandom_range(4, 30);
    tmo_list[6] = $urandom();
    for (int p = 0; p < 8; p++) begin
      settle();
      write_reg(CFG_EXPECTED, {29'($urandom()), 3'(kw_list[p])});
      write_reg(CFG_TIMEOUT, tmo_list[p]);
      quiet = (p == 3);
      target = words_sent + 48;
      while (words_sent < target) random_command();
    end
    settle();
    quiet = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_timeout_bounds();
    test_unused_keyword();
    test_reply_overflow();
    test_random_traffic();
    settle();
    if (bad_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
